// ===== design/sitrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sitrc_pkg: shared types and constants for the radix text converter
// Configuration layout, register indexes, back-end states and symbol lookup.
// ----------------------------------------------------------------------------
package sitrc_pkg;

   localparam int DEF_MAX_RADIX   = 16;
   localparam int DEF_NUMBER_BITS = 32;

   localparam int RADIX_W    = 5;   // base_length register width
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;
   localparam int CHAR_W     = 8;
   localparam int SYM_COUNT  = 16;
   localparam int SYM_IDX_W  = 4;
   localparam int DIV_STEPS  = 8;   // quotient bits resolved per cycle
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CHAR_W-1:0] SIGN_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] SIGN_MINUS = 8'h2D;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BASE_LENGTH = 2'd0,
      CSR_CHARS_LOW   = 2'd1,
      CSR_CHARS_HIGH  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_DIGITS
   } back_state_type;

   typedef struct packed {
      logic [RADIX_W-1:0]    base_length;
      logic [CSR_DATA_W-1:0] chars_low;
      logic [CSR_DATA_W-1:0] chars_high;
   } cfg_type;

   function automatic logic [CHAR_W-1:0] symbol_at(input cfg_type cfg,
                                                   input logic [SYM_IDX_W-1:0] idx);
      logic [5:0] pos;
      pos = {idx[2:0], 3'b000};
      return idx[3] ? cfg.chars_high[pos +: CHAR_W] : cfg.chars_low[pos +: CHAR_W];
   endfunction

endpackage
`default_nettype wire

// ===== design/sitrc_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sitrc_fifo: short first-in first-out queue
// Register-based queue with full and empty flags, used between stages.
// ----------------------------------------------------------------------------
module sitrc_fifo
   import sitrc_pkg::*;
#(
   parameter int WIDTH = CHAR_W + 1,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] wr_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      rd_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

// ===== design/sitrc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sitrc_front: input classification
// Checks the configured symbol set and forms sign and unsigned magnitude.
// ----------------------------------------------------------------------------
module sitrc_front
   import sitrc_pkg::*;
#(
   parameter int MAX_RADIX   = DEF_MAX_RADIX,
   parameter int NUMBER_BITS = DEF_NUMBER_BITS
) (
   input  wire cfg_type                 cfg,
   input  wire logic                    in_push,
   input  wire logic signed [NUMBER_BITS-1:0] in_number,
   output logic                         mid_push,
   output logic [RADIX_W-1:0]           mid_radix,
   output logic                         mid_negative,
   output logic [NUMBER_BITS-1:0]       mid_magnitude,
   input  wire logic                    mid_full
);

   logic [CHAR_W-1:0]      sym [SYM_COUNT];
   logic                   base_ok;
   logic [NUMBER_BITS-1:0] raw;

   always_comb begin
      for (int i = 0; i < SYM_COUNT; i++) begin
         sym[i] = symbol_at(cfg, SYM_IDX_W'(i));
      end
   end

   // length range, no '+' or '-', and pairwise compare over the symbols in use
   always_comb begin
      base_ok = (cfg.base_length >= RADIX_W'(2)) &&
                (cfg.base_length <= RADIX_W'(MAX_RADIX));
      for (int i = 0; i < SYM_COUNT; i++) begin
         if (RADIX_W'(i) < cfg.base_length) begin
            if (sym[i] == SIGN_PLUS || sym[i] == SIGN_MINUS) begin
               base_ok = 1'b0;
            end
            for (int j = i + 1; j < SYM_COUNT; j++) begin
               if (RADIX_W'(j) < cfg.base_length && sym[j] == sym[i]) begin
                  base_ok = 1'b0;
               end
            end
         end
      end
   end

   assign raw           = in_number;
   assign mid_negative  = raw[NUMBER_BITS-1];
   assign mid_magnitude = mid_negative ? (~raw + NUMBER_BITS'(1)) : raw;
   assign mid_radix     = cfg.base_length;
   // beats with an unusable symbol set are taken and dropped
   assign mid_push      = in_push && !mid_full && base_ok;

endmodule
`default_nettype wire

// ===== design/sitrc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sitrc_back: digit generation and character emission
// Repeated long division by the radix, then symbols most significant first.
// ----------------------------------------------------------------------------
module sitrc_back
   import sitrc_pkg::*;
#(
   parameter int MAX_RADIX   = DEF_MAX_RADIX,
   parameter int NUMBER_BITS = DEF_NUMBER_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire cfg_type                cfg,
   input  wire logic                   mid_empty,
   input  wire logic [RADIX_W-1:0]     mid_radix,
   input  wire logic                   mid_negative,
   input  wire logic [NUMBER_BITS-1:0] mid_magnitude,
   output logic                        mid_pop,
   input  wire logic                   out_full,
   output logic                        out_push,
   output logic [CHAR_W-1:0]           out_char,
   output logic                        out_last
);

   localparam int DIV_CYC = (NUMBER_BITS + DIV_STEPS - 1) / DIV_STEPS;
   localparam int PAD_W   = DIV_CYC * DIV_STEPS;
   localparam int CYC_W   = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
   localparam int CNT_W   = $clog2(NUMBER_BITS + 1);
   localparam int IDX_W   = $clog2(NUMBER_BITS);
   localparam int DIGIT_W = $clog2(MAX_RADIX);

   back_state_type       state_ff, state_in;
   logic [PAD_W-1:0]     work_ff, work_in;
   logic [RADIX_W-1:0]   rem_ff, rem_in;
   logic [RADIX_W-1:0]   radix_ff, radix_in;
   logic                 neg_ff, neg_in;
   logic [CYC_W-1:0]     cyc_ff, cyc_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [DIGIT_W-1:0]   digit_store [NUMBER_BITS];

   logic [RADIX_W-1:0]   step_rem;
   logic [DIV_STEPS-1:0] step_q;
   logic [PAD_W-1:0]     quot;
   logic [PAD_W+DIV_STEPS-1:0] shifted;
   logic                 digit_done;
   logic                 last_digit;
   logic [CNT_W-1:0]     count_next;

   // restoring division, one quotient bit per step on a narrow remainder
   always_comb begin
      step_rem = rem_ff;
      step_q   = '0;
      for (int i = 0; i < DIV_STEPS; i++) begin
         step_rem = {step_rem[RADIX_W-2:0], work_ff[PAD_W-1-i]};
         if (step_rem >= radix_ff) begin
            step_rem = step_rem - radix_ff;
            step_q[DIV_STEPS-1-i] = 1'b1;
         end
      end
   end

   assign shifted    = {work_ff, step_q};
   assign quot       = shifted[PAD_W-1:0];
   assign digit_done = (state_ff == ST_DIVIDE) && (cyc_ff == CYC_W'(DIV_CYC - 1));
   assign count_next = count_ff + CNT_W'(1);
   assign last_digit = (quot == '0) || (count_next == CNT_W'(NUMBER_BITS));

   always_comb begin
      state_in = state_ff;
      work_in  = work_ff;
      rem_in   = rem_ff;
      radix_in = radix_ff;
      neg_in   = neg_ff;
      cyc_in   = cyc_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      mid_pop  = 1'b0;
      out_push = 1'b0;
      out_char = '0;
      out_last = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!mid_empty) begin
               mid_pop  = 1'b1;
               work_in  = PAD_W'(mid_magnitude);
               rem_in   = '0;
               radix_in = mid_radix;
               neg_in   = mid_negative;
               cyc_in   = '0;
               count_in = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            work_in = quot;
            if (digit_done) begin
               count_in = count_next;
               rem_in   = '0;
               cyc_in   = '0;
               if (last_digit) begin
                  idx_in   = count_ff[IDX_W-1:0];
                  state_in = neg_ff ? ST_SIGN : ST_DIGITS;
               end
            end else begin
               rem_in = step_rem;
               cyc_in = cyc_ff + CYC_W'(1);
            end
         end
         ST_SIGN: begin
            if (!out_full) begin
               out_push = 1'b1;
               out_char = SIGN_MINUS;
               state_in = ST_DIGITS;
            end
         end
         ST_DIGITS: begin
            out_char = symbol_at(cfg, SYM_IDX_W'(digit_store[idx_ff]));
            out_last = (idx_ff == '0);
            if (!out_full) begin
               out_push = 1'b1;
               if (idx_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff - IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cyc_ff   <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         cyc_ff   <= cyc_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      rem_ff   <= rem_in;
      radix_ff <= radix_in;
      neg_ff   <= neg_in;
      idx_ff   <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (digit_done) begin
         digit_store[count_ff[IDX_W-1:0]] <= step_rem[DIGIT_W-1:0];
      end
   end

`ifndef ASSERT_OFF
   a_rem_below_radix: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (rem_ff < radix_ff) && (radix_ff >= RADIX_W'(2)))
      else $error("remainder not below radix during division");

   a_sign_only_negative: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SIGN) |-> neg_ff)
      else $error("sign emitted for a non-negative number");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(NUMBER_BITS))
      else $error("digit count beyond number width");
`endif

endmodule
`default_nettype wire

// ===== design/signed_integer_to_radix_chars.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// signed_integer_to_radix_chars: signed integer to text in a set radix
// Converts each number to characters in a configured symbol set.
// ----------------------------------------------------------------------------
// usage
//   req_ channel: a beat carrying req_number is taken when req_push is high
//   and req_full is low. rsp_ channel: while rsp_empty is low the oldest
//   character waits on rsp_character / rsp_last; rsp_pop takes it.
//   csr_ port: csr_write stores csr_data into register csr_index
//   (0 base_length, 1 symbols 0-7, 2 symbols 8-15); write only when idle.
//   an unusable symbol set (length outside 2..MAX_RADIX, a repeat, '+' or
//   '-') makes a beat vanish with no characters.
// timing
//   a beat leaves the input queue, then each digit is worked out in the
//   shared divider (8 quotient bits a cycle), then the characters go out
//   one per cycle while the output queue has room. the back end takes
//   the next beat only when the last character of a beat has gone out;
//   the input queue holds two beats meanwhile.
// reset and stalls
//   synchronous reset clears the queues, the sequencer and the configuration
//   to zero (no valid symbol set). a stalled receiver fills the two-deep
//   output queue, then the emitter waits, then the input queue fills and
//   raises req_full. no character is lost or repeated.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_chars
   import sitrc_pkg::*;
#(
   parameter int MAX_RADIX   = DEF_MAX_RADIX,
   parameter int NUMBER_BITS = DEF_NUMBER_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   input  wire logic signed [NUMBER_BITS-1:0] req_number,
   output logic                               req_full,
   output logic                               rsp_empty,
   input  wire logic                          rsp_pop,
   output logic [CHAR_W-1:0]                  rsp_character,
   output logic                               rsp_last,
   input  wire logic                          csr_write,
   input  wire logic [CSR_IDX_W-1:0]          csr_index,
   input  wire logic [CSR_DATA_W-1:0]         csr_data
);

   localparam int MID_W = RADIX_W + 1 + NUMBER_BITS;
   localparam int OUT_W = CHAR_W + 1;

   cfg_type cfg_ff, cfg_in;

   // front to back beat
   logic                   mid_push, mid_pop, mid_full, mid_empty;
   logic [RADIX_W-1:0]     f_radix, b_radix;
   logic                   f_negative, b_negative;
   logic [NUMBER_BITS-1:0] f_magnitude, b_magnitude;
   logic [MID_W-1:0]       mid_rd;

   // back to result queue
   logic              out_push, out_full, out_last;
   logic [CHAR_W-1:0] out_char;
   logic [OUT_W-1:0]  out_rd;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_BASE_LENGTH: cfg_in.base_length = csr_data[RADIX_W-1:0];
            CSR_CHARS_LOW:   cfg_in.chars_low   = csr_data;
            CSR_CHARS_HIGH:  cfg_in.chars_high  = csr_data;
            default: begin
               // no register at this index
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sitrc_front #(
      .MAX_RADIX   (MAX_RADIX),
      .NUMBER_BITS (NUMBER_BITS)
   ) u_front (
      .cfg           (cfg_ff),
      .in_push       (req_push),
      .in_number     (req_number),
      .mid_push      (mid_push),
      .mid_radix     (f_radix),
      .mid_negative  (f_negative),
      .mid_magnitude (f_magnitude),
      .mid_full      (mid_full)
   );

   // input side sees the classification queue directly
   assign req_full = mid_full;

   sitrc_fifo #(
      .WIDTH (MID_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_mid_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (mid_push),
      .wr_data ({f_radix, f_negative, f_magnitude}),
      .full    (mid_full),
      .pop     (mid_pop),
      .rd_data (mid_rd),
      .empty   (mid_empty)
   );

   assign b_radix     = mid_rd[MID_W-1 -: RADIX_W];
   assign b_negative  = mid_rd[NUMBER_BITS];
   assign b_magnitude = mid_rd[NUMBER_BITS-1:0];

   sitrc_back #(
      .MAX_RADIX   (MAX_RADIX),
      .NUMBER_BITS (NUMBER_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .mid_empty     (mid_empty),
      .mid_radix     (b_radix),
      .mid_negative  (b_negative),
      .mid_magnitude (b_magnitude),
      .mid_pop       (mid_pop),
      .out_full      (out_full),
      .out_push      (out_push),
      .out_char      (out_char),
      .out_last      (out_last)
   );

   // result queue parts the emitter from the receiver
   sitrc_fifo #(
      .WIDTH (OUT_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_out_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (out_push),
      .wr_data ({out_char, out_last}),
      .full    (out_full),
      .pop     (rsp_pop),
      .rd_data (out_rd),
      .empty   (rsp_empty)
   );

   assign rsp_character = out_rd[OUT_W-1:1];
   assign rsp_last      = out_rd[0];

endmodule
`default_nettype wire
